// ----- rtl/core/b64_pkg.sv -----
package b64_pkg;

    // character classes
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_PAD  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    localparam logic [7:0] PAD_CHAR       = 8'h3D;
    localparam logic [7:0] PLUS_CHAR      = 8'h2B;
    localparam logic [7:0] SLASH_CHAR     = 8'h2F;
    localparam logic [7:0] UPPER_FIRST    = 8'h41;
    localparam logic [7:0] UPPER_LAST     = 8'h5A;
    localparam logic [7:0] LOWER_FIRST    = 8'h61;
    localparam logic [7:0] LOWER_LAST     = 8'h7A;
    localparam logic [7:0] DIGIT_FIRST    = 8'h30;
    localparam logic [7:0] DIGIT_LAST     = 8'h39;
    localparam logic [5:0] LOWER_BASE     = 6'd26;
    localparam logic [5:0] DIGIT_BASE     = 6'd52;
    localparam logic [5:0] PLUS_VALUE     = 6'd62;
    localparam logic [5:0] SLASH_VALUE    = 6'd63;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] val;
    } t_class;

    // one unit of work for the back end: an error or a decoded group
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nbytes;
        logic        err;
        logic        last;
        logic        nul;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_class b64_classify(input logic [7:0] ch);
        t_class r;
        logic [7:0] d;
        r.kind = KIND_BAD;
        r.val  = '0;
        d      = '0;
        if (ch inside {[UPPER_FIRST:UPPER_LAST]}) begin
            d      = ch - UPPER_FIRST;
            r.kind = KIND_DATA;
            r.val  = d[5:0];
        end else if (ch inside {[LOWER_FIRST:LOWER_LAST]}) begin
            d      = ch - LOWER_FIRST;
            r.kind = KIND_DATA;
            r.val  = d[5:0] + LOWER_BASE;
        end else if (ch inside {[DIGIT_FIRST:DIGIT_LAST]}) begin
            d      = ch - DIGIT_FIRST;
            r.kind = KIND_DATA;
            r.val  = d[5:0] + DIGIT_BASE;
        end else if (ch == PLUS_CHAR) begin
            r.kind = KIND_DATA;
            r.val  = PLUS_VALUE;
        end else if (ch == SLASH_CHAR) begin
            r.kind = KIND_DATA;
            r.val  = SLASH_VALUE;
        end else if (ch == PAD_CHAR) begin
            r.kind = KIND_PAD;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/b64_if.sv -----
interface b64_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, ch, last_char, input ready);
    modport sink   (input valid, ch, last_char, output ready);
endinterface

interface b64_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       error;

    modport source (output valid, data_byte, last_byte, error, input ready);
    modport sink   (input valid, data_byte, last_byte, error, output ready);
endinterface

interface b64_cfg_if;
    logic valid;
    logic ready;
    logic append_nul;

    modport source (output valid, append_nul, input ready);
    modport sink   (input valid, append_nul, output ready);
endinterface

// ----- rtl/core/b64_front.sv -----
module b64_front
    import b64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64_char_if.sink    i_char,
    b64_cfg_if.sink     i_cfg,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_job        o_job
);

    logic [17:0] r_buf, n_buf;
    logic [1:0]  r_count, n_count;
    logic [1:0]  r_pad, n_pad;
    logic        r_append_nul;

    t_class      cls;
    logic [1:0]  kind;
    logic        accept;
    logic        is_pad;
    logic [1:0]  pads;

    assign i_cfg.ready  = 1'b1;
    assign i_char.ready = !i_qstat.full;
    assign accept       = i_char.valid && i_char.ready;

    always_comb begin
        cls  = b64_classify(i_char.ch);
        kind = cls.kind;
        if (kind == KIND_PAD && r_count < 2'd2) begin
            kind = KIND_BAD;
        end
        if (kind == KIND_DATA && r_pad != 2'd0) begin
            kind = KIND_BAD;
        end
        is_pad = (kind == KIND_PAD);
        pads   = r_pad + {1'b0, is_pad};

        n_buf   = r_buf;
        n_count = r_count;
        n_pad   = r_pad;
        o_push  = 1'b0;
        o_job   = '0;

        if (accept) begin
            if (kind == KIND_BAD) begin
                // drop the group, report one error
                o_push      = 1'b1;
                o_job.err   = 1'b1;
                o_job.last  = i_char.last_char;
                o_job.nbytes = 2'd1;
                n_buf   = '0;
                n_count = '0;
                n_pad   = '0;
            end else if (r_count != 2'd3) begin
                n_buf   = {r_buf[11:0], cls.val};
                n_count = r_count + 2'd1;
                n_pad   = pads;
                if (i_char.last_char) begin
                    // text ends inside a group
                    o_push       = 1'b1;
                    o_job.err    = 1'b1;
                    o_job.last   = 1'b1;
                    o_job.nbytes = 2'd1;
                    n_buf   = '0;
                    n_count = '0;
                    n_pad   = '0;
                end
            end else begin
                o_push       = 1'b1;
                o_job.word   = {r_buf, cls.val};
                o_job.nbytes = (pads >= 2'd2) ? 2'd1 : 2'd3 - pads;
                o_job.last   = i_char.last_char;
                o_job.nul    = i_char.last_char && r_append_nul;
                n_buf   = '0;
                n_count = '0;
                n_pad   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf        <= '0;
            r_count      <= '0;
            r_pad        <= '0;
            r_append_nul <= 1'b0;
        end else begin
            r_buf   <= n_buf;
            r_count <= n_count;
            r_pad   <= n_pad;
            if (i_cfg.valid) begin
                r_append_nul <= i_cfg.append_nul;
            end
        end
    end

endmodule

// ----- rtl/core/b64_queue.sv -----
module b64_queue
    import b64_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_qstat o_qstat,
    output t_job   o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_qstat.full  = (r_count == CNT_W'(DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/b64_back.sv -----
module b64_back
    import b64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    b64_byte_if.source  o_byte
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;
    logic       r_err;
    logic [1:0] r_idx;

    logic [1:0] total_m1;
    logic       load;
    logic [7:0] res_data;
    logic       res_last;
    logic       res_err;

    assign o_byte.valid     = r_valid;
    assign o_byte.data_byte = r_data;
    assign o_byte.last_byte = r_last;
    assign o_byte.error     = r_err;

    always_comb begin
        total_m1 = i_job.err ? 2'd0 : (i_job.nbytes - 2'd1) + {1'b0, i_job.nul};
        load     = (!r_valid || o_byte.ready) && !i_qstat.empty;
        o_pop    = load && (r_idx == total_m1);

        res_data = '0;
        res_last = 1'b0;
        res_err  = 1'b0;
        if (i_job.err) begin
            res_err  = 1'b1;
            res_last = i_job.last;
        end else if (r_idx < i_job.nbytes) begin
            case (r_idx)
                2'd0:    res_data = i_job.word[23:16];
                2'd1:    res_data = i_job.word[15:8];
                2'd2:    res_data = i_job.word[7:0];
                default: res_data = '0;
            endcase
            res_last = i_job.last && !i_job.nul && (r_idx == i_job.nbytes - 2'd1);
        end else begin
            // terminator after the final group
            res_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= res_data;
            r_last <= res_last;
            r_err  <= res_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= o_pop ? 2'd0 : r_idx + 2'd1;
            end else if (o_byte.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/core/base64_decoder.sv -----
// Streaming Base64 decoder, standard alphabet with '=' padding.
// i_char takes one character per transfer; last_char marks the end of the text.
// o_byte gives one result per transfer: a decoded byte, or an error result
// (data_byte zero, error set) for a bad character or a text that ends inside
// a group. last_byte marks the final result of a text.
// i_cfg writes append_nul; when set, a zero byte follows the data of a
// complete final group. Write it only while the decoder is idle.
// Throughput: one character per cycle in while the queue has room, one result
// per cycle out while the receiver is ready. A group of four characters yields
// three bytes (one or two with padding), so a stream of full groups never backs
// up. A group passes through the group queue, then the output register.
// A receiver stall fills the QUEUE_DEPTH-entry group queue, after which
// i_char.ready drops; nothing is lost. Reset clears the partial group, the
// queue, the output register and append_nul.
module base64_decoder
    import b64_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64_char_if.sink    i_char,
    b64_cfg_if.sink     i_cfg,
    b64_byte_if.source  o_byte
);

    logic   push, pop;
    t_job   job_in, job_head;
    t_qstat qstat;

    b64_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_cfg   (i_cfg),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (job_in)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (job_head)
    );

    b64_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

// ----- rtl/core/b64_checker.sv -----
module b64_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_data,
    input logic       i_out_last,
    input logic       i_out_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data) && $stable(i_out_last) && $stable(i_out_error))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> i_out_data == 8'd0)
        else $error("error result carries data");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind base64_decoder b64_checker u_b64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_data  (o_byte.data_byte),
    .i_out_last  (o_byte.last_byte),
    .i_out_error (o_byte.error)
);

// ----- tb/base64_decoder_tb.sv -----
`timescale 1ns / 1ps

module base64_decoder_tb
    import b64_pkg::*;
();

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       error;
    } t_byte_result;

    // Tracks the group being gathered and the bytes it must produce.
    class byte_ledger;
        logic          append_nul;
        logic [17:0]   sextets;
        int unsigned   held;
        int unsigned   pads;
        t_byte_result  pending_bytes[$];
        int            failures;

        function new();
            append_nul = 1'b0;
            failures   = 0;
            clear_group();
        endfunction

        function void clear_group();
            sextets = '0;
            held    = 0;
            pads    = 0;
        endfunction

        function void push_byte(input logic [7:0] d, input logic l, input logic e);
            t_byte_result r;
            r.data_byte = d;
            r.last_byte = l;
            r.error     = e;
            pending_bytes.push_back(r);
        endfunction

        function void decode_char(input logic [7:0] c, input logic l);
            logic [1:0]  kind;
            logic [5:0]  v;
            logic [23:0] word;
            int unsigned npads;
            int unsigned nbytes;
            logic        nul;
            kind = KIND_BAD;
            v    = '0;
            if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
                kind = KIND_DATA;
                v    = 6'(c - UPPER_FIRST);
            end else if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
                kind = KIND_DATA;
                v    = 6'(c - LOWER_FIRST) + LOWER_BASE;
            end else if (c >= DIGIT_FIRST && c <= DIGIT_LAST) begin
                kind = KIND_DATA;
                v    = 6'(c - DIGIT_FIRST) + DIGIT_BASE;
            end else if (c == PLUS_CHAR) begin
                kind = KIND_DATA;
                v    = PLUS_VALUE;
            end else if (c == SLASH_CHAR) begin
                kind = KIND_DATA;
                v    = SLASH_VALUE;
            end else if (c == PAD_CHAR) begin
                kind = KIND_PAD;
            end

            // a pad too early or data after a pad breaks the group
            if (kind == KIND_PAD && held < 2) kind = KIND_BAD;
            if (kind == KIND_DATA && pads != 0) kind = KIND_BAD;

            if (kind == KIND_BAD) begin
                clear_group();
                push_byte(8'h00, l, 1'b1);
                return;
            end

            if (held < 3) begin
                sextets = {sextets[11:0], v};
                held++;
                if (kind == KIND_PAD) pads++;
                if (l) begin
                    clear_group();
                    push_byte(8'h00, 1'b1, 1'b1);
                end
                return;
            end

            word   = {sextets, v};
            npads  = pads + ((kind == KIND_PAD) ? 1 : 0);
            nbytes = (npads >= 2) ? 1 : 3 - npads;
            nul    = l && append_nul;
            clear_group();
            for (int i = 0; i < nbytes; i++)
                push_byte(word[23 - 8 * i -: 8], l && !nul && (i + 1 == nbytes), 1'b0);
            if (nul) push_byte(8'h00, 1'b1, 1'b0);
        endfunction

        function void report(input string field, input int exp_v, input int act_v);
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v,
                     act_v);
            failures++;
        endfunction

        function void match_byte(input logic [7:0] d, input logic l, input logic e);
            t_byte_result r;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %0h last %0b err %0b",
                         $time, d, l, e);
                failures++;
                return;
            end
            r = pending_bytes.pop_front();
            if (d !== r.data_byte) report("data_byte", r.data_byte, d);
            if (l !== r.last_byte) report("last_byte", r.last_byte, l);
            if (e !== r.error)     report("error", r.error, e);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    b64_char_if char_if ();
    b64_cfg_if  cfg_if ();
    b64_byte_if byte_if ();

    base64_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_char  (char_if),
        .i_cfg   (cfg_if),
        .o_byte  (byte_if)
    );

    byte_ledger ledger = new();

    bit sender_calm   = 1'b0;
    bit sink_calm     = 1'b0;
    bit hold_request  = 1'b0;
    int chars_sent    = 0;

    always #1 clk = ~clk;

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic logic [7:0] sextet_char(input int v);
        if (v < 26) return UPPER_FIRST + 8'(v);
        if (v < 52) return LOWER_FIRST + 8'(v - 26);
        if (v < 62) return DIGIT_FIRST + 8'(v - 52);
        if (v == 62) return PLUS_CHAR;
        return SLASH_CHAR;
    endfunction

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_char(input logic [7:0] c, input logic l);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            char_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.ch        <= c;
        char_if.last_char <= l;
        do @(posedge clk); while (!char_if.ready);
        ledger.decode_char(c, l);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input logic end_mark);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_mark && (i == s.len() - 1));
    endtask

    task automatic drain();
        char_if.valid <= 1'b0;
        while (ledger.pending_bytes.size() != 0) @(negedge clk);
        // let a group still in flight without results settle
        repeat (8) @(negedge clk);
    endtask

    task automatic write_append_nul(input logic v);
        cfg_if.valid      <= 1'b1;
        cfg_if.append_nul <= v;
        do @(posedge clk); while (!cfg_if.ready);
        ledger.append_nul = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic add_group(ref logic [7:0] text[$], input int npads);
        for (int i = 0; i < 4 - npads; i++) text.push_back(sextet_char($urandom_range(0, 63)));
        for (int i = 0; i < npads; i++) text.push_back(PAD_CHAR);
    endtask

    task automatic send_random_text();
        logic [7:0] text[$];
        int style;
        int groups;
        int pos;
        style  = $urandom_range(0, 99);
        groups = $urandom_range(0, 3);
        if (style >= 85) begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (int g = 0; g < groups; g++)
                add_group(text, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
            add_group(text, $urandom_range(0, 2));
            if (style >= 70) begin
                pos = $urandom_range(0, text.size() - 1);
                case ($urandom_range(0, 2))
                    0: repeat ($urandom_range(1, 3)) if (text.size() > 1) void'(text.pop_back());
                    1: text[pos] = 8'($urandom_range(0, 255));
                    default: text[pos] = PAD_CHAR;
                endcase
            end
        end
        for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
    endtask

    task automatic random_phase(input int stop_at);
        while (chars_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0) sender_calm = ~sender_calm;
            if ($urandom_range(0, 7) == 0) sink_calm = ~sink_calm;
            send_random_text();
        end
    endtask

    initial begin : byte_sink
        int stall;
        stall = 0;
        byte_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall = 80;
            end
            if (stall > 0) begin
                byte_if.ready <= 1'b0;
                stall--;
            end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
                byte_if.ready <= 1'b0;
                stall = pick_gap(1'b0);
            end else begin
                byte_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
        if (rst_n && byte_if.valid && byte_if.ready)
            ledger.match_byte(byte_if.data_byte, byte_if.last_byte, byte_if.error);

    initial begin : stimulus
        int base;
        char_if.valid     = 1'b0;
        char_if.ch        = 8'h00;
        char_if.last_char = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.append_nul = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_append_nul(1'b1);
        send_text("AZaz", 1'b0);
        send_text("09+/", 1'b1);
        send_text("QQ==", 1'b0);
        send_text("QUI=", 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'h80, 1'b1);
        send_text("=A=", 1'b0);
        send_text("AB=C", 1'b0);
        send_text("AB", 1'b1);
        drain();

        write_append_nul(1'b0);
        base = chars_sent;
        // long receiver stall while characters keep coming
        sender_calm  = 1'b1;
        hold_request = 1'b1;
        random_phase(base + 190);
        drain();

        write_append_nul(1'b1);
        random_phase(base + 380);
        drain();

        if (ledger.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/b64_pkg.sv
rtl/core/b64_if.sv
rtl/core/b64_front.sv
rtl/core/b64_queue.sv
rtl/core/b64_back.sv
rtl/core/base64_decoder.sv
rtl/core/b64_checker.sv
tb/base64_decoder_tb.sv
